@@ rtl/service_ratio_process_scheduler_assert.svh @@
// ----------------------------------------------------------------------------
// service ratio scheduler assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SERVICE_RATIO_PROCESS_SCHEDULER_ASSERT_SVH
`define SERVICE_RATIO_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication, off during reset
`define SRPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srps check failed");

// next-cycle implication, off during reset
`define SRPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srps check failed");

// next-cycle implication that also holds through reset
`define SRPS_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srps check failed");

`endif

@@ rtl/srps_pkg.sv @@
// ----------------------------------------------------------------------------
// srps_pkg
// shared types and constants of the service ratio scheduler
// ----------------------------------------------------------------------------
package srps_pkg;

  // default sizes
  localparam int SLOTS_DEF     = 32;
  localparam int TIME_BITS_DEF = 48;

  // field widths
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 5;
  localparam int ID_W      = 22;
  localparam int NOW_W     = 48;
  localparam int OUTC_W    = 2;
  localparam int RUN_W     = 30;
  localparam int STATUS_W  = 3;
  localparam int ACTIVE_W  = 6;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 30;

  // multiplier digit
  localparam int DIGIT_W = 16;

  // register reset values
  localparam logic [ACTIVE_W-1:0] MAX_ACTIVE_RST = 6'd3;
  localparam logic [RUN_W-1:0]    QUANTUM_RST    = 30'd50000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 1'b1;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADMIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

  // report outcomes
  localparam logic [OUTC_W-1:0] OUT_TERM  = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_FULL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_BLOCK = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_NONE  = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

  // controller states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMD  = 6'b000010,
    S_WAKE = 6'b000100,
    S_PICK = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

@@ rtl/srps_cell.sv @@
// ----------------------------------------------------------------------------
// srps_cell
// one process table entry in the rotating ring
// ----------------------------------------------------------------------------
module srps_cell
  import srps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic                 occ_in,
  input  logic                 blk_in,
  input  logic [ID_W-1:0]      id_in,
  input  logic [TIME_BITS-1:0] start_in,
  input  logic [TIME_BITS-1:0] svc_in,
  input  logic [TIME_BITS-1:0] wake_in,
  output logic                 occ,
  output logic                 blk,
  output logic [ID_W-1:0]      id,
  output logic [TIME_BITS-1:0] start,
  output logic [TIME_BITS-1:0] svc,
  output logic [TIME_BITS-1:0] wake
);

  logic                 occ_r, blk_r;
  logic [ID_W-1:0]      id_r;
  logic [TIME_BITS-1:0] start_r, svc_r, wake_r;

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      blk_r <= 1'b0;
    end else if (shift) begin
      occ_r <= occ_in;
      blk_r <= blk_in;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift) begin
      id_r    <= id_in;
      start_r <= start_in;
      svc_r   <= svc_in;
      wake_r  <= wake_in;
    end
  end

  assign occ   = occ_r;
  assign blk   = blk_r;
  assign id    = id_r;
  assign start = start_r;
  assign svc   = svc_r;
  assign wake  = wake_r;

endmodule

@@ rtl/srps_ratio.sv @@
// ----------------------------------------------------------------------------
// srps_ratio
// digit-serial cross multiply compare: sa * tb < sb * ta
// ----------------------------------------------------------------------------
module srps_ratio
  import srps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] sa,
  input  logic [TIME_BITS-1:0] ta,
  input  logic [TIME_BITS-1:0] sb,
  input  logic [TIME_BITS-1:0] tb,
  output logic                 done,
  output logic                 less
);

  localparam int DIGITS = (TIME_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int DW     = DIGITS * DIGIT_W;
  localparam int PW     = 2 * TIME_BITS;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] a1_r, a1_nxt, a2_r, a2_nxt;
  logic [DW-1:0]        b1_r, b1_nxt, b2_r, b2_nxt;
  logic [PW-1:0]        acc1_r, acc1_nxt, acc2_r, acc2_nxt;
  logic [TIME_BITS+DIGIT_W-1:0] prod1, prod2;

  // partial products on the top digit
  assign prod1 = a1_r * b1_r[DW-1 -: DIGIT_W];
  assign prod2 = a2_r * b2_r[DW-1 -: DIGIT_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a1_nxt   = a1_r;
    a2_nxt   = a2_r;
    b1_nxt   = b1_r;
    b2_nxt   = b2_r;
    acc1_nxt = acc1_r;
    acc2_nxt = acc2_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a1_nxt   = sa;
      a2_nxt   = sb;
      b1_nxt   = DW'(tb);
      b2_nxt   = DW'(ta);
      acc1_nxt = '0;
      acc2_nxt = '0;
    end else if (busy_r) begin
      // shift accumulate, most significant digit first
      acc1_nxt = (acc1_r << DIGIT_W) + PW'(prod1);
      acc2_nxt = (acc2_r << DIGIT_W) + PW'(prod2);
      b1_nxt   = b1_r << DIGIT_W;
      b2_nxt   = b2_r << DIGIT_W;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= a1_nxt;
    a2_r   <= a2_nxt;
    b1_r   <= b1_nxt;
    b2_r   <= b2_nxt;
    acc1_r <= acc1_nxt;
    acc2_r <= acc2_nxt;
  end

  assign done = done_r;
  assign less = acc1_r < acc2_r;

endmodule

@@ rtl/service_ratio_process_scheduler.sv @@
// ----------------------------------------------------------------------------
// service_ratio_process_scheduler
// least service ratio process table scheduler on a rotating ring of entries
// ----------------------------------------------------------------------------
// The in_ stream carries one command per item: admit, select or report.
// Every command produces exactly one item on the out_ stream.
// The table is a ring of SLOTS entry cells that rotates by one each step;
// the controller works on the entry at the head of the ring.
// Admit and report take one revolution of the ring.
// Select takes two revolutions (wake pass, pick pass) and, for each ready
// entry after the first, a cross multiply in the digit-serial comparator.
// One item is worked on at a time.
// in_tready is high whenever the controller is idle, also while a result
// waits in the output register; a stalled receiver holds the result and
// the next result waits in the controller until the register frees.
// Reset (rst_n low, synchronous) empties the table, loads max_active 3
// and quantum_ns 50000000, and drops out_tvalid.
// ----------------------------------------------------------------------------
module service_ratio_process_scheduler
  import srps_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cmd, slot, proc_id, now_ns, outcome, run_ns, wake_ns
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // status, chosen_slot, chosen_id, clock_ns, active_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // ring of entries
  logic                 c_occ [SLOTS];
  logic                 c_blk [SLOTS];
  logic [ID_W-1:0]      c_id  [SLOTS];
  logic [TIME_BITS-1:0] c_start [SLOTS];
  logic [TIME_BITS-1:0] c_svc   [SLOTS];
  logic [TIME_BITS-1:0] c_wake  [SLOTS];

  logic                 shift;
  logic                 h_occ, h_blk;
  logic [ID_W-1:0]      h_id;
  logic [TIME_BITS-1:0] h_start, h_svc, h_wake;

  for (genvar k = 0; k < SLOTS; k++) begin : g_ring
    if (k < SLOTS - 1) begin : g_mid
      srps_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .occ_in(c_occ[k+1]), .blk_in(c_blk[k+1]), .id_in(c_id[k+1]),
        .start_in(c_start[k+1]), .svc_in(c_svc[k+1]), .wake_in(c_wake[k+1]),
        .occ(c_occ[k]), .blk(c_blk[k]), .id(c_id[k]),
        .start(c_start[k]), .svc(c_svc[k]), .wake(c_wake[k])
      );
    end else begin : g_tail
      srps_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .occ_in(h_occ), .blk_in(h_blk), .id_in(h_id),
        .start_in(h_start), .svc_in(h_svc), .wake_in(h_wake),
        .occ(c_occ[k]), .blk(c_blk[k]), .id(c_id[k]),
        .start(c_start[k]), .svc(c_svc[k]), .wake(c_wake[k])
      );
    end
  end

  // configuration registers
  logic [ACTIVE_W-1:0] max_active_r;
  logic [RUN_W-1:0]    quantum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_active_r <= MAX_ACTIVE_RST;
      quantum_r    <= QUANTUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ACTIVE: max_active_r <= cfg_data[ACTIVE_W-1:0];
        REG_QUANTUM:    quantum_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // controller registers
  state_t               state_r, state_nxt;
  logic [SW-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [ID_W-1:0]      pid_r, pid_nxt;
  logic [OUTC_W-1:0]    outc_r, outc_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [TIME_BITS-1:0] wakein_r, wakein_nxt;
  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0]     nblk_r, nblk_nxt, nready_r, nready_nxt;
  logic                 have_low_r, have_low_nxt, jumped_r, jumped_nxt;
  logic [SW-1:0]        low_r, low_nxt;
  logic [TIME_BITS-1:0] low_wake_r, low_wake_nxt;
  logic                 have_best_r, have_best_nxt;
  logic [SW-1:0]        best_r, best_nxt;
  logic [ID_W-1:0]      best_id_r, best_id_nxt;
  logic [TIME_BITS-1:0] best_s_r, best_s_nxt, best_t_r, best_t_nxt, t_r, t_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // head helpers
  logic                 hit, last_pos, eff_blk, ready, take_low, rat_start;
  logic                 rat_done, rat_less;
  logic [TIME_BITS-1:0] t_cur, low_wake_sel;
  logic [TIME_BITS:0]   sat_sum;
  logic [TIME_BITS-1:0] sat_val;
  logic [RUN_W-1:0]     addend;
  logic [STATUS_W-1:0]  sel_status;

  assign hit      = 32'(slot_r) == 32'(pos_r);
  assign last_pos = pos_r == SW'(SLOTS - 1);
  assign eff_blk  = c_blk[0] && !(jumped_r && low_r == pos_r);
  assign ready    = c_occ[0] && !eff_blk;
  assign t_cur    = (clock_r > c_start[0]) ? clock_r - c_start[0] : TIME_BITS'(1);
  assign take_low = !have_low_r || c_wake[0] < low_wake_r;
  assign low_wake_sel = take_low ? c_wake[0] : low_wake_r;

  // saturating service accumulation
  assign addend  = (outc_r == OUT_FULL) ? quantum_r : run_r;
  assign sat_sum = {1'b0, c_svc[0]} + (TIME_BITS+1)'(addend);
  assign sat_val = sat_sum[TIME_BITS] ? '1 : sat_sum[TIME_BITS-1:0];

  // select outcome
  always_comb begin
    if (32'(nready_r) > 32'(max_active_r)) sel_status = ST_OVER;
    else if (!have_best_r)                  sel_status = ST_NONE;
    else                                    sel_status = ST_OK;
  end

  srps_ratio #(.TIME_BITS(TIME_BITS)) u_ratio (
    .clk(clk), .rst_n(rst_n), .start(rat_start),
    .sa(c_svc[0]), .ta(t_cur), .sb(best_s_r), .tb(best_t_r),
    .done(rat_done), .less(rat_less)
  );

  // controller next state
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    active_nxt    = active_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    pid_nxt       = pid_r;
    outc_nxt      = outc_r;
    run_nxt       = run_r;
    wakein_nxt    = wakein_r;
    clock_nxt     = clock_r;
    status_nxt    = status_r;
    nblk_nxt      = nblk_r;
    nready_nxt    = nready_r;
    have_low_nxt  = have_low_r;
    jumped_nxt    = jumped_r;
    low_nxt       = low_r;
    low_wake_nxt  = low_wake_r;
    have_best_nxt = have_best_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    best_s_nxt    = best_s_r;
    best_t_nxt    = best_t_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    shift         = 1'b0;
    rat_start     = 1'b0;
    h_occ         = c_occ[0];
    h_blk         = c_blk[0];
    h_id          = c_id[0];
    h_start       = c_start[0];
    h_svc         = c_svc[0];
    h_wake        = c_wake[0];
    in_tready     = state_r == S_IDLE;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_tdata[1:0];
          slot_nxt      = in_tdata[6:2];
          pid_nxt       = in_tdata[28:7];
          clock_nxt     = TIME_BITS'(in_tdata[76:29]);
          outc_nxt      = in_tdata[78:77];
          run_nxt       = in_tdata[108:79];
          wakein_nxt    = TIME_BITS'(in_tdata[156:109]);
          nblk_nxt      = '0;
          nready_nxt    = '0;
          have_low_nxt  = 1'b0;
          jumped_nxt    = 1'b0;
          have_best_nxt = 1'b0;
          case (in_tdata[1:0])
            CMD_ADMIT: begin
              status_nxt = ST_REFUSED;
              state_nxt  = S_CMD;
            end
            CMD_REPORT: begin
              status_nxt = ST_BAD;
              state_nxt  = S_CMD;
            end
            CMD_SELECT: begin
              status_nxt = ST_OK;
              state_nxt  = S_WAKE;
            end
            default: begin
              status_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      // one revolution, the addressed entry is changed as it passes
      S_CMD: begin
        shift = 1'b1;
        if (hit) begin
          if (cmd_r == CMD_ADMIT) begin
            if (!c_occ[0] && 32'(active_r) < 32'(max_active_r)) begin
              h_occ      = 1'b1;
              h_blk      = 1'b0;
              h_id       = pid_r;
              h_start    = clock_r;
              h_svc      = '0;
              active_nxt = active_r + 1'b1;
              status_nxt = ST_OK;
            end
          end else if (c_occ[0] && !c_blk[0] && outc_r != OUT_NONE) begin
            h_svc      = sat_val;
            status_nxt = ST_OK;
            if (outc_r == OUT_TERM) begin
              h_occ      = 1'b0;
              active_nxt = active_r - 1'b1;
            end else if (outc_r == OUT_BLOCK) begin
              h_blk  = 1'b1;
              h_wake = wakein_r;
            end
          end
        end
        pos_nxt = last_pos ? '0 : pos_r + 1'b1;
        if (last_pos) state_nxt = S_DONE;
      end

      // wake pass with the all-blocked clock jump
      S_WAKE: begin
        shift = 1'b1;
        if (c_occ[0] && c_blk[0]) begin
          if (clock_r > c_wake[0]) begin
            h_blk = 1'b0;
          end else begin
            nblk_nxt = nblk_r + 1'b1;
            if (take_low) begin
              low_nxt      = pos_r;
              low_wake_nxt = c_wake[0];
              have_low_nxt = 1'b1;
            end
            if (!jumped_r && 32'(nblk_nxt) == 32'(max_active_r)) begin
              clock_nxt  = low_wake_sel;
              jumped_nxt = 1'b1;
            end
          end
        end
        pos_nxt = last_pos ? '0 : pos_r + 1'b1;
        if (last_pos) state_nxt = S_PICK;
      end

      // pick pass, entry woken by the jump is released here
      S_PICK: begin
        h_blk = eff_blk;
        t_nxt = t_cur;
        if (ready && have_best_r) begin
          rat_start = 1'b1;
          state_nxt = S_MUL;
        end else begin
          shift = 1'b1;
          if (ready) begin
            nready_nxt    = nready_r + 1'b1;
            have_best_nxt = 1'b1;
            best_nxt      = pos_r;
            best_id_nxt   = c_id[0];
            best_s_nxt    = c_svc[0];
            best_t_nxt    = t_cur;
          end
          pos_nxt = last_pos ? '0 : pos_r + 1'b1;
          if (last_pos) state_nxt = S_DONE;
        end
      end

      S_MUL: begin
        h_blk = eff_blk;
        if (rat_done) begin
          shift      = 1'b1;
          nready_nxt = nready_r + 1'b1;
          if (rat_less) begin
            best_nxt    = pos_r;
            best_id_nxt = c_id[0];
            best_s_nxt  = c_svc[0];
            best_t_nxt  = t_r;
          end
          pos_nxt   = last_pos ? '0 : pos_r + 1'b1;
          state_nxt = last_pos ? S_DONE : S_PICK;
        end
      end

      // hand the item to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[77:30] = NOW_W'(clock_r);
          out_data_nxt[83:78] = ACTIVE_W'(active_r);
          if (cmd_r == CMD_SELECT) begin
            out_data_nxt[2:0] = sel_status;
            if (sel_status == ST_OK) begin
              out_data_nxt[7:3]  = SLOT_W'(best_r);
              out_data_nxt[29:8] = best_id_r;
            end
          end else begin
            out_data_nxt[2:0] = status_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    slot_r      <= slot_nxt;
    pid_r       <= pid_nxt;
    outc_r      <= outc_nxt;
    run_r       <= run_nxt;
    wakein_r    <= wakein_nxt;
    clock_r     <= clock_nxt;
    status_r    <= status_nxt;
    nblk_r      <= nblk_nxt;
    nready_r    <= nready_nxt;
    have_low_r  <= have_low_nxt;
    jumped_r    <= jumped_nxt;
    low_r       <= low_nxt;
    low_wake_r  <= low_wake_nxt;
    have_best_r <= have_best_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    best_s_r    <= best_s_nxt;
    best_t_r    <= best_t_nxt;
    t_r         <= t_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/srps_checker.sv @@
// ----------------------------------------------------------------------------
// srps_checker
// port level checks of the service ratio scheduler
// ----------------------------------------------------------------------------
`include "service_ratio_process_scheduler_assert.svh"

module srps_checker
  import srps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // a stalled result stays offered
  `SRPS_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid)

  // no result straight out of reset
  `SRPS_ASSERT_ALWAYS(a_rst, !rst_n, !out_tvalid)

  // chosen entry only reported with status ok
  `SRPS_ASSERT_NOW(a_chosen, out_tvalid && out_tdata[2:0] != ST_OK, out_tdata[29:3] == '0)

  // one command cannot finish in the cycle after it is taken
  `SRPS_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)

endmodule

bind service_ratio_process_scheduler srps_checker u_srps_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the least service ratio process scheduler: a
// directed table then random admit/select/report traffic, each result
// compared against an in-bench model of the process table
// ----------------------------------------------------------------------------
module tb_top;
  import srps_pkg::*;

  localparam int NSLOT       = 32;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int DRAIN_CYC   = 300;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 5000;
  localparam logic [47:0] TMAX = {48{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   pid;
    logic [47:0]       now;
    logic [OUTC_W-1:0] outcome;
    logic [RUN_W-1:0]  run;
    logic [47:0]       wake;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   cslot;
    logic [ID_W-1:0]     cid;
    logic [47:0]         clock;
    logic [ACTIVE_W-1:0] active;
  } sched_res_t;

  typedef struct {
    cmd_item_t           item;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [ACTIVE_W-1:0] active;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // table model
  logic [5:0]  mdl_max_active;
  logic [29:0] mdl_quantum;
  bit          tbl_occ [NSLOT];
  bit          tbl_blk [NSLOT];
  logic [21:0] tbl_id  [NSLOT];
  logic [47:0] tbl_start [NSLOT];
  logic [47:0] tbl_serv  [NSLOT];
  logic [47:0] tbl_wake  [NSLOT];

  sched_res_t expected_results [$];
  dir_row_t   dir_rows [$];
  int         mismatches = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  int         hold_left = 0;
  int         stall_cnt = 0;
  bit         in_fire_nx, out_fire_nx;
  logic [47:0] sim_now = '0;

  service_ratio_process_scheduler i_dut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tvalid, .out_tready, .cfg_we, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // occupied entries
  function automatic int occ_count();
    int n = 0;
    for (int i = 0; i < NSLOT; i++) n += tbl_occ[i];
    return n;
  endfunction

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  // sa/ta < sb/tb by cross product
  function automatic bit ratio_lt(logic [47:0] sa, logic [47:0] ta,
                                  logic [47:0] sb, logic [47:0] tb);
    logic [95:0] l, r;
    l = {48'd0, sa} * {48'd0, tb};
    r = {48'd0, sb} * {48'd0, ta};
    return l < r;
  endfunction

  // apply one command to the table model, return its result
  function automatic sched_res_t schedule_step(cmd_item_t it);
    sched_res_t  r;
    int          nblk, nready, low, best;
    bit          have_low, jumped, have_best;
    logic [47:0] clk_v, t, bs, bt;
    r = '0;
    clk_v = it.now;
    case (it.cmd)
      CMD_ADMIT: begin
        if (tbl_occ[it.slot] || occ_count() >= int'(mdl_max_active)) begin
          r.status = ST_REFUSED;
        end else begin
          tbl_occ[it.slot] = 1;
          tbl_blk[it.slot] = 0;
          tbl_id[it.slot] = it.pid;
          tbl_start[it.slot] = it.now;
          tbl_serv[it.slot] = '0;
          r.status = ST_OK;
        end
      end
      CMD_SELECT: begin
        nblk = 0; nready = 0; low = 0; best = 0;
        have_low = 0; jumped = 0; have_best = 0;
        bs = '0; bt = 48'd1;
        // wake pass with at most one clock jump
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_occ[i] && tbl_blk[i]) begin
            if (clk_v > tbl_wake[i]) begin
              tbl_blk[i] = 0;
            end else begin
              nblk++;
              if (!have_low || tbl_wake[i] < tbl_wake[low]) begin
                low = i;
                have_low = 1;
              end
              if (!jumped && nblk == int'(mdl_max_active)) begin
                clk_v = tbl_wake[low];
                tbl_blk[low] = 0;
                jumped = 1;
              end
            end
          end
        end
        // pick pass
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_occ[i] && !tbl_blk[i]) begin
            nready++;
            t = (clk_v > tbl_start[i]) ? clk_v - tbl_start[i] : 48'd1;
            if (!have_best || ratio_lt(tbl_serv[i], t, bs, bt)) begin
              have_best = 1;
              best = i;
              bs = tbl_serv[i];
              bt = t;
            end
          end
        end
        if (nready > int'(mdl_max_active)) r.status = ST_OVER;
        else if (!have_best) r.status = ST_NONE;
        else begin
          r.status = ST_OK;
          r.cslot = best[4:0];
          r.cid = tbl_id[best];
        end
      end
      CMD_REPORT: begin
        if (!tbl_occ[it.slot] || tbl_blk[it.slot] || it.outcome == OUT_NONE) begin
          r.status = ST_BAD;
        end else if (it.outcome == OUT_FULL) begin
          tbl_serv[it.slot] = add_sat(tbl_serv[it.slot], {18'd0, mdl_quantum});
        end else begin
          tbl_serv[it.slot] = add_sat(tbl_serv[it.slot], {18'd0, it.run});
          if (it.outcome == OUT_TERM) begin
            tbl_occ[it.slot] = 0;
          end else begin
            tbl_blk[it.slot] = 1;
            tbl_wake[it.slot] = it.wake;
          end
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.clock = clk_v;
    r.active = ACTIVE_W'(occ_count());
    return r;
  endfunction

  // receiver: random back-pressure plus an occasional long hold
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // handshakes are looked at mid-cycle, they complete at the next edge
  always @(negedge clk) begin
    sched_res_t got, exp_r;
    in_fire_nx = in_tvalid && in_tready;
    out_fire_nx = out_tvalid && out_tready;
    if (rst_n && out_fire_nx) begin
      got = {out_tdata[2:0], out_tdata[7:3], out_tdata[29:8], out_tdata[77:30],
             out_tdata[83:78]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d slot %0d/%0d id %h/%h",
                     exp_r.status, got.status, exp_r.cslot, got.cslot, exp_r.cid, got.cid,
                     " clock %h/%h active %0d/%0d",
                     exp_r.clock, got.clock, exp_r.active, got.active);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || in_fire_nx || out_fire_nx) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_cmd(cmd_item_t it, bit typed, logic [STATUS_W-1:0] st,
                          logic [ACTIVE_W-1:0] act);
    int         gap;
    bit         rdy;
    sched_res_t r;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, it.wake, it.run, it.outcome, it.now, it.pid, it.slot, it.cmd};
    do begin
      @(negedge clk) rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    r = schedule_step(it);
    if (typed) begin
      r = '0;
      r.status = st;
      r.clock = it.now;
      r.active = act;
    end
    expected_results.push_back(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_ACTIVE) mdl_max_active = val[5:0];
    else mdl_quantum = val;
  endtask

  function automatic void add_row(logic [1:0] c, logic [4:0] s, logic [21:0] p,
                                  logic [47:0] n, logic [1:0] o, logic [29:0] rn,
                                  logic [47:0] w, bit typed = 0,
                                  logic [2:0] st = '0, logic [5:0] act = '0);
    dir_row_t d;
    d.item = '{c, s, p, n, o, rn, w};
    d.typed = typed;
    d.status = st;
    d.active = act;
    dir_rows.push_back(d);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // mostly well-formed commands shaped by the current table
  function automatic cmd_item_t rand_cmd();
    cmd_item_t it;
    int        k, pick, cands [$];
    it.pid = 22'($urandom);
    it.slot = 5'($urandom);
    it.outcome = 2'($urandom_range(2));
    it.run = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(100000000));
    if ($urandom_range(49) == 0) sim_now = rand48();
    else sim_now = add_sat(sim_now, 48'($urandom_range(20000000)));
    it.now = sim_now;
    it.wake = ($urandom_range(19) == 0) ? rand48()
              : add_sat(sim_now, 48'($urandom_range(60000000)));
    k = $urandom_range(99);
    if (k < 3) begin
      it.cmd = CMD_INVALID;
    end else if (k < 33) begin
      it.cmd = CMD_ADMIT;
      for (int i = 0; i < NSLOT; i++) if (!tbl_occ[i]) cands.push_back(i);
      if (cands.size() != 0 && $urandom_range(9) != 0)
        it.slot = 5'(cands[$urandom_range(cands.size() - 1)]);
    end else if (k < 63) begin
      it.cmd = CMD_SELECT;
    end else begin
      it.cmd = CMD_REPORT;
      for (int i = 0; i < NSLOT; i++) if (tbl_occ[i] && !tbl_blk[i]) cands.push_back(i);
      if (cands.size() != 0 && $urandom_range(9) != 0) begin
        pick = cands[$urandom_range(cands.size() - 1)];
        it.slot = 5'(pick);
      end
      if ($urandom_range(32) == 0) it.outcome = OUT_NONE;
    end
    return it;
  endfunction

  // main sequence
  initial begin
    logic [5:0]  ma_set [RAND_PHASES] = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd8, 6'd3};
    logic [29:0] q_set  [RAND_PHASES] = '{30'h3FFFFFFF, 30'd1, 30'd1000, 30'd77,
                                          30'd50000000, 30'd12345};
    mdl_max_active = MAX_ACTIVE_RST;
    mdl_quantum = QUANTUM_RST;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_occ[i] = 0; tbl_blk[i] = 0; tbl_id[i] = '0;
      tbl_start[i] = '0; tbl_serv[i] = '0; tbl_wake[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset register values
    add_row(CMD_SELECT, 0, 0, 48'd10, 0, 0, 0, 1, ST_NONE, 0);
    add_row(CMD_INVALID, 5'd7, 22'h3FFFFF, TMAX, OUT_NONE, 30'h3FFFFFFF, TMAX, 1, ST_BAD, 0);
    add_row(CMD_REPORT, 0, 0, 48'd20, OUT_TERM, 5, 0, 1, ST_BAD, 0);
    add_row(CMD_ADMIT, 0, 22'h3FFFFF, 48'd0, 0, 0, 0, 1, ST_OK, 1);
    add_row(CMD_ADMIT, 0, 22'd5, 48'd1, 0, 0, 0, 1, ST_REFUSED, 1);
    add_row(CMD_ADMIT, 31, 22'd0, 48'd100, 0, 0, 0, 1, ST_OK, 2);
    add_row(CMD_ADMIT, 5, 22'h155555, 48'd200, 0, 0, 0, 1, ST_OK, 3);
    add_row(CMD_ADMIT, 6, 22'h2AAAAA, 48'd300, 0, 0, 0, 1, ST_REFUSED, 3);
    add_row(CMD_SELECT, 0, 0, 48'd1000, 0, 0, 0);
    add_row(CMD_REPORT, 0, 0, 48'd1000, OUT_NONE, 0, 0, 1, ST_BAD, 3);
    add_row(CMD_REPORT, 0, 0, 48'd1100, OUT_FULL, 30'h3FFFFFFF, 0);
    add_row(CMD_SELECT, 0, 0, 48'd1200, 0, 0, 0);
    add_row(CMD_REPORT, 31, 0, 48'd1200, OUT_BLOCK, 30'h3FFFFFFF, 48'd5000);
    add_row(CMD_REPORT, 31, 0, 48'd1300, OUT_FULL, 0, 0, 1, ST_BAD, 3);
    add_row(CMD_REPORT, 5, 0, 48'd1300, OUT_BLOCK, 30'd7, 48'd3000);
    add_row(CMD_REPORT, 0, 0, 48'd1400, OUT_BLOCK, 30'd9, 48'd4000);
    // all three blocked: clock jumps to the earliest wake
    add_row(CMD_SELECT, 0, 0, 48'd1500, 0, 0, 0);
    add_row(CMD_SELECT, 0, 0, TMAX, 0, 0, 0);
    add_row(CMD_REPORT, 0, 0, TMAX, OUT_TERM, 30'h3FFFFFFF, 0);
    add_row(CMD_ADMIT, 0, 22'h0F0F0F, TMAX, 0, 0, 0);
    // clock not after start: time in system taken as one
    add_row(CMD_SELECT, 0, 0, 48'd0, 0, 0, 0);
    add_row(CMD_REPORT, 5, 0, 48'd50, OUT_TERM, 0, 0);
    add_row(CMD_SELECT, 0, 0, 48'd60, 0, 0, 0);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].status,
               dir_rows[i].active);
    drain();

    // random phases, one register setting and one idling mix each
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_MAX_ACTIVE, {24'd0, ma_set[p]});
      write_reg(REG_QUANTUM, q_set[p]);
      case (p % 3)
        0: begin send_idle = 10; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 10; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (p == 2) hold_left = HOLD_CYC;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // one pause until the block has gone quiet
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
        send_cmd(rand_cmd(), 0, '0, '0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
